/* rtl/palette_effect_slots_defines.svh */
// assertion macros shared by the palette effect slots checker
`ifndef PALETTE_EFFECT_SLOTS_DEFINES_SVH
`define PALETTE_EFFECT_SLOTS_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define PES_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("palette effect slots check failed");

// condition holds in the cycle after the trigger
`define PES_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("palette effect slots check failed");

`endif

/* rtl/pes_pkg.sv */
// shared constants and beat types of the palette effect slots block
package pes_pkg;

    localparam int SLOTS       = 8;
    localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [2:0] OP_FADE    = 3'd0;
    localparam logic [2:0] OP_CYCLE   = 3'd1;
    localparam logic [2:0] OP_FLASH   = 3'd2;
    localparam logic [2:0] OP_TICK    = 3'd3;
    localparam logic [2:0] OP_STOP    = 3'd4;
    localparam logic [2:0] OP_STOPALL = 3'd5;
    localparam logic [2:0] OP_QUERY   = 3'd6;

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_FADE  = 2'd1;
    localparam logic [1:0] MODE_CYCLE = 2'd2;
    localparam logic [1:0] MODE_FLASH = 2'd3;

    localparam logic [1:0] KIND_ACK    = 2'd0;
    localparam logic [1:0] KIND_WRITE  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    typedef struct packed {
        logic [2:0]  op;
        logic [1:0]  plane;
        logic [3:0]  palette_index;
        logic [47:0] palette_now;
        logic [47:0] palette_target;
        logic [7:0]  rate;
        logic [2:0]  slot_number;
    } in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  slot_out;
        logic        failed;
        logic [1:0]  plane_out;
        logic [3:0]  palette_index_out;
        logic [47:0] palette_out;
        logic        active;
        logic        last;
    } res_t;

    // classified command handed from the front to the back
    typedef struct packed {
        logic        start;
        logic        fail_zero;
        logic [1:0]  mode;
        logic        tick;
        logic        stop;
        logic        stopall;
        logic        query;
        logic [1:0]  plane;
        logic [3:0]  palette_index;
        logic [47:0] palette_now;
        logic [47:0] palette_target;
        logic [7:0]  rate;
        logic [7:0]  rate_eff;
        logic [2:0]  slot_number;
    } cmd_t;

    // one slot record of the slot memory
    typedef struct packed {
        logic [1:0]  plane;
        logic [3:0]  palette_number;
        logic [7:0]  rate;
        logic [7:0]  countdown;
        logic [7:0]  flash_left;
        logic [47:0] original;
        logic [47:0] goal;
        logic [47:0] current;
    } rec_t;

endpackage

/* rtl/pes_front.sv */
// front end: accepts input beats, classifies them and queues the commands
module pes_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  pes_pkg::in_t  item,
    output logic          cmd_valid,
    output pes_pkg::cmd_t cmd,
    input  logic          cmd_pop
);
    import pes_pkg::*;

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    cmd_t       cls;
    logic       do_push, do_pop;

    always_comb
    begin
        cls                = '0;
        cls.start          = item.op inside {OP_FADE, OP_CYCLE, OP_FLASH};
        cls.fail_zero      = (item.op == OP_FLASH) && (item.rate == 8'd0);
        cls.tick           = (item.op == OP_TICK);
        cls.stop           = (item.op == OP_STOP);
        cls.stopall        = (item.op == OP_STOPALL);
        cls.query          = (item.op == OP_QUERY);
        cls.plane          = item.plane;
        cls.palette_index  = item.palette_index;
        cls.palette_now    = item.palette_now;
        cls.palette_target = item.palette_target;
        cls.rate           = item.rate;
        cls.rate_eff       = (item.rate == 8'd0) ? 8'd1 : item.rate;
        cls.slot_number    = item.slot_number;
        case (item.op)
            OP_FADE:  cls.mode = MODE_FADE;
            OP_CYCLE: cls.mode = MODE_CYCLE;
            OP_FLASH: cls.mode = MODE_FLASH;
            default:  cls.mode = MODE_IDLE;
        endcase
    end

    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

/* rtl/pes_back.sv */
// back end: slot sequencer with the slot memory, produces result beats
module pes_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  pes_pkg::cmd_t cmd,
    output logic          cmd_pop,
    input  logic          oq_full,
    output logic          oq_push,
    output pes_pkg::res_t oq_data
);
    import pes_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CMD   = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_EX    = 3'd3;
    localparam logic [2:0] S_ACK   = 3'd4;
    localparam logic [2:0] S_FLUSH = 3'd5;

    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

    logic [2:0]        state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    res_t              pend_reg, pend_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [1:0]        mode_reg [SLOTS];
    logic [1:0]        mode_next [SLOTS];

    rec_t              mem [SLOTS];
    rec_t              rd_reg;
    logic              we, re;
    logic [SLOT_W-1:0] waddr, raddr;
    rec_t              wdata;

    logic              prod, flush, can, room, adv, walk;
    res_t              prod_res;
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic [SLOT_W-1:0] sn_idx;
    logic              sn_ok;
    logic [47:0]       fade_p, cycle_p;
    logic              fade_done;
    logic [7:0]        cd_dec, fl_dec;
    rec_t              start_rec;
    logic [11:0]       flash_c;

    function automatic res_t mk_res(input logic [1:0] kind, input logic [SLOT_W-1:0] slot,
                                    input logic failed, input logic [1:0] plane,
                                    input logic [3:0] pal, input logic [47:0] colors,
                                    input logic active);
        res_t r;
        r                   = '0;
        r.kind              = kind;
        r.slot_out          = 3'(slot);
        r.failed            = failed;
        r.plane_out         = plane;
        r.palette_index_out = pal;
        r.palette_out       = colors;
        r.active            = active;
        return r;
    endfunction

    // lowest idle slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (mode_reg[i] == MODE_IDLE)
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    // one channel step toward the goal on all twelve channels
    always_comb
    begin
        logic [3:0] a, b, n;
        fade_p    = '0;
        fade_done = 1'b1;
        for (int e = 0; e < 4; e++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                a = rd_reg.current[12*e + 4*c +: 4];
                b = rd_reg.goal[12*e + 4*c +: 4];
                if (a < b)
                    n = a + 4'd1;
                else if (a > b)
                    n = a - 4'd1;
                else
                    n = a;
                fade_p[12*e + 4*c +: 4] = n;
                if (n != b)
                    fade_done = 1'b0;
            end
        end
    end

    // entry 1 takes 2, 2 takes 3, 3 takes old 1
    assign cycle_p = {rd_reg.current[23:12], rd_reg.current[47:36],
                      rd_reg.current[35:24], rd_reg.current[11:0]};
    assign cd_dec  = rd_reg.countdown - 8'd1;
    assign fl_dec  = rd_reg.flash_left - 8'd1;

    assign sn_idx  = SLOT_W'(cmd_reg.slot_number);
    assign sn_ok   = (int'(cmd_reg.slot_number) < SLOTS);
    assign walk    = cmd_reg.tick || cmd_reg.stopall;
    assign flash_c = cmd_reg.palette_target[11:0];

    always_comb
    begin
        start_rec                = '0;
        start_rec.plane          = cmd_reg.plane;
        start_rec.palette_number = cmd_reg.palette_index;
        start_rec.rate           = cmd_reg.rate_eff;
        start_rec.countdown      = (cmd_reg.mode == MODE_FADE) ? 8'd1 : cmd_reg.rate_eff;
        start_rec.flash_left     = cmd_reg.rate;
        start_rec.original       = cmd_reg.palette_now;
        start_rec.goal           = cmd_reg.palette_target;
        start_rec.current        = cmd_reg.palette_now;
    end

    assign room = (cnt_reg < CNT_W'(MAX_RESULTS));
    assign can  = !pend_valid_reg || !oq_full || !room;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        idx_next   = idx_reg;
        slot_next  = slot_reg;
        mode_next  = mode_reg;
        cmd_pop    = 1'b0;
        prod       = 1'b0;
        prod_res   = '0;
        flush      = 1'b0;
        adv        = 1'b0;
        we         = 1'b0;
        waddr      = idx_reg;
        wdata      = rd_reg;
        re         = 1'b0;
        raddr      = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop    = 1'b1;
                    cmd_next   = cmd;
                    state_next = S_CMD;
                end
            end
            S_CMD:
            begin
                if (cmd_reg.start)
                begin
                    prod = 1'b1;
                    if (!free_found || cmd_reg.fail_zero)
                    begin
                        prod_res = mk_res(KIND_ACK, '0, 1'b1, 2'd0, 4'd0, 48'd0, 1'b0);
                        if (can)
                            state_next = S_FLUSH;
                    end
                    else
                    begin
                        if (cmd_reg.mode == MODE_FLASH)
                            prod_res = mk_res(KIND_WRITE, free_idx, 1'b0, cmd_reg.plane,
                                              cmd_reg.palette_index,
                                              {flash_c, flash_c, flash_c, flash_c}, 1'b0);
                        else
                            prod_res = mk_res(KIND_ACK, free_idx, 1'b0, 2'd0, 4'd0,
                                              48'd0, 1'b0);
                        if (can)
                        begin
                            we                  = 1'b1;
                            waddr               = free_idx;
                            wdata               = start_rec;
                            mode_next[free_idx] = cmd_reg.mode;
                            slot_next           = free_idx;
                            state_next = (cmd_reg.mode == MODE_FLASH) ? S_ACK : S_FLUSH;
                        end
                    end
                end
                else if (walk)
                begin
                    idx_next   = '0;
                    state_next = S_RD;
                end
                else if (cmd_reg.stop)
                begin
                    if (sn_ok && mode_reg[sn_idx] != MODE_IDLE)
                    begin
                        idx_next   = sn_idx;
                        state_next = S_RD;
                    end
                    else
                        state_next = S_FLUSH;
                end
                else if (cmd_reg.query)
                begin
                    prod     = 1'b1;
                    prod_res = mk_res(KIND_STATUS, SLOT_W'(cmd_reg.slot_number), 1'b0,
                                      2'd0, 4'd0, 48'd0,
                                      sn_ok && (mode_reg[sn_idx] != MODE_IDLE));
                    prod_res.slot_out = cmd_reg.slot_number;
                    if (can)
                        state_next = S_FLUSH;
                end
                else
                    state_next = S_FLUSH;
            end
            S_RD:
            begin
                if (walk && mode_reg[idx_reg] == MODE_IDLE)
                    adv = 1'b1;
                else
                begin
                    re         = 1'b1;
                    state_next = S_EX;
                end
            end
            S_EX:
            begin
                if (cmd_reg.tick)
                begin
                    case (mode_reg[idx_reg])
                        MODE_FADE, MODE_CYCLE:
                        begin
                            if (cd_dec != 8'd0)
                            begin
                                we              = 1'b1;
                                wdata.countdown = cd_dec;
                                adv             = 1'b1;
                            end
                            else
                            begin
                                prod     = 1'b1;
                                prod_res = mk_res(KIND_WRITE, idx_reg, 1'b0, rd_reg.plane,
                                                  rd_reg.palette_number,
                                                  (mode_reg[idx_reg] == MODE_FADE) ?
                                                  fade_p : cycle_p, 1'b0);
                                if (can)
                                begin
                                    we              = 1'b1;
                                    wdata.countdown = rd_reg.rate;
                                    wdata.current   = prod_res.palette_out;
                                    if (mode_reg[idx_reg] == MODE_FADE && fade_done)
                                        mode_next[idx_reg] = MODE_IDLE;
                                    adv = 1'b1;
                                end
                            end
                        end
                        MODE_FLASH:
                        begin
                            if (fl_dec != 8'd0)
                            begin
                                we               = 1'b1;
                                wdata.flash_left = fl_dec;
                                adv              = 1'b1;
                            end
                            else
                            begin
                                prod     = 1'b1;
                                prod_res = mk_res(KIND_WRITE, idx_reg, 1'b0, rd_reg.plane,
                                                  rd_reg.palette_number, rd_reg.original,
                                                  1'b0);
                                if (can)
                                begin
                                    mode_next[idx_reg] = MODE_IDLE;
                                    adv                = 1'b1;
                                end
                            end
                        end
                        default:
                            adv = 1'b1;
                    endcase
                end
                else
                begin
                    // stop or stop-all: restore the original palette and free the slot
                    prod     = 1'b1;
                    prod_res = mk_res(KIND_WRITE, idx_reg, 1'b0, rd_reg.plane,
                                      rd_reg.palette_number, rd_reg.original, 1'b0);
                    if (can)
                    begin
                        mode_next[idx_reg] = MODE_IDLE;
                        adv                = 1'b1;
                    end
                end
            end
            S_ACK:
            begin
                prod     = 1'b1;
                prod_res = mk_res(KIND_ACK, slot_reg, 1'b0, 2'd0, 4'd0, 48'd0, 1'b0);
                if (can)
                    state_next = S_FLUSH;
            end
            S_FLUSH:
            begin
                flush = 1'b1;
                if (!pend_valid_reg || !oq_full)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase

        if (adv)
        begin
            if (!walk || idx_reg == LAST_IDX)
                state_next = S_FLUSH;
            else
            begin
                idx_next   = idx_reg + 1'b1;
                state_next = S_RD;
            end
        end
    end

    // one result held back so the last one of a command can be marked
    always_comb
    begin
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        cnt_next        = cnt_reg;
        oq_push         = 1'b0;
        oq_data         = pend_reg;
        if (state_reg == S_IDLE)
            cnt_next = '0;
        if (prod && can && room)
        begin
            oq_push         = pend_valid_reg;
            pend_next       = prod_res;
            pend_valid_next = 1'b1;
            cnt_next        = cnt_reg + 1'b1;
        end
        if (flush && pend_valid_reg && !oq_full)
        begin
            oq_push         = 1'b1;
            oq_data.last    = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pend_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            idx_reg        <= '0;
            for (int i = 0; i < SLOTS; i++)
                mode_reg[i] <= MODE_IDLE;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            cnt_reg        <= cnt_next;
            idx_reg        <= idx_next;
            mode_reg       <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        slot_reg <= slot_next;
        pend_reg <= pend_next;
    end

    // slot memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rd_reg <= mem[raddr];
    end

endmodule

/* rtl/pes_out_queue.sv */
// two-entry result queue in front of the result port
module pes_out_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  pes_pkg::res_t data,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output pes_pkg::res_t head
);
    import pes_pkg::*;

    res_t       q_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign head    = q_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    assign count_next = count_reg + {1'b0, do_push} - {1'b0, do_pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg ^ do_push;
            rd_ptr_reg <= rd_ptr_reg ^ do_pop;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_reg[wr_ptr_reg] <= data;
    end

endmodule

/* rtl/palette_effect_slots.sv */
// top level of the palette effect slots block
// A bank of eight effect slots that animate four-entry palettes of 12-bit
// colors; commands go in as queue beats (push/full) and palette writes,
// start acknowledgments and status answers come out as queue beats
// (empty/pop), the final beat of each command carrying last. A tick or a
// stop-all visits the slots one after another, and every busy slot is
// first read from the registered slot memory and then executed. Two
// command beats queue up in front of the sequencer and two result beats
// behind it, so either side may stall on its own.
module palette_effect_slots (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  pes_pkg::in_t  item,
    output logic          empty,
    input  logic          pop,
    output pes_pkg::res_t result
);
    import pes_pkg::*;

    // front to back command hand-off
    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;

    // back to result queue
    logic oq_push;
    res_t oq_data;
    logic oq_full;

    // accepts and classifies command beats
    pes_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // walks the slots and holds their state
    pes_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .oq_full   (oq_full),
        .oq_push   (oq_push),
        .oq_data   (oq_data)
    );

    // result beats wait here for the consumer
    pes_out_queue u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (oq_push),
        .data  (oq_data),
        .full  (oq_full),
        .pop   (pop),
        .empty (empty),
        .head  (result)
    );

endmodule

/* rtl/pes_checker.sv */
// port-level checker for the palette effect slots block and its bind
`include "palette_effect_slots_defines.svh"

module pes_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          full,
    input logic          empty,
    input logic          pop,
    input pes_pkg::res_t result
);
    import pes_pkg::*;

    // a waiting result beat stays until taken
    `PES_ASSERT_NEXT(a_hold_valid, !empty && !pop, !empty)
    `PES_ASSERT_NEXT(a_hold_data, !empty && !pop, $stable(result))
    // both queues come out of reset empty
    `PES_ASSERT_NOW(a_reset_clear, !$past(rst_n), empty && !full)
    // a refused start is a lone acknowledgment
    `PES_ASSERT_NOW(a_fail_alone, !empty && result.failed, result.last && result.kind == KIND_ACK)

endmodule

bind palette_effect_slots pes_checker u_pes_checker (.*);

/* test/testbench.sv */
// self-checking testbench for the palette effect slots block
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pes_pkg::*;

    // op code with no command behind it, the block ignores it
    localparam logic [2:0] OP_UNUSED = 3'd7;

    localparam int RANDOM_COMMANDS = 330;
    // quiet cycles after the last expected beat
    localparam int TAIL_CYCLES = 60;
    // generous ceiling: 330 commands at up to 8 beats each, with both sides
    // stalling at random, fit many times over
    localparam int CYCLE_LIMIT = 300000;
    localparam int IDLE_PCT = 29;

    logic  clk;
    logic  rst_n;
    logic  push;
    logic  full;
    in_t   item;
    logic  empty;
    logic  pop;
    res_t  result;

    // both sides stop idling while this is set
    bit          steady;
    int unsigned cycles_run;

    // ------------------------------------------------------------------
    // slot bank predictor and the queue of beats it expects
    // ------------------------------------------------------------------
    class effect_slot_scoreboard;
        logic [1:0]  slot_mode [SLOTS];
        logic [1:0]  slot_plane [SLOTS];
        logic [3:0]  slot_pal [SLOTS];
        logic [7:0]  slot_rate [SLOTS];
        logic [7:0]  slot_count [SLOTS];
        logic [7:0]  slot_flash_left [SLOTS];
        logic [47:0] slot_original [SLOTS];
        logic [47:0] slot_goal [SLOTS];
        logic [47:0] slot_current [SLOTS];

        res_t        beats_due [$];
        res_t        burst [$];
        int unsigned mismatches;

        function new();
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_mode[i]       = MODE_IDLE;
                slot_plane[i]      = '0;
                slot_pal[i]        = '0;
                slot_rate[i]       = '0;
                slot_count[i]      = '0;
                slot_flash_left[i] = '0;
                slot_original[i]   = '0;
                slot_goal[i]       = '0;
                slot_current[i]    = '0;
            end
            mismatches = 0;
        endfunction

        // beats past the per-command cap are dropped, state still moves
        function void add_beat(res_t r);
            if (burst.size() < MAX_RESULTS)
                burst.push_back(r);
        endfunction

        function void add_write(int s, logic [47:0] colors);
            res_t r;
            r = '0;
            r.kind              = KIND_WRITE;
            r.slot_out          = s[2:0];
            r.plane_out         = slot_plane[s];
            r.palette_index_out = slot_pal[s];
            r.palette_out       = colors;
            add_beat(r);
        endfunction

        function void add_ack(int s, logic fail);
            res_t r;
            r = '0;
            r.kind     = KIND_ACK;
            r.slot_out = s[2:0];
            r.failed   = fail;
            add_beat(r);
        endfunction

        function void stop_effect(int s);
            if (slot_mode[s] != MODE_IDLE)
            begin
                add_write(s, slot_original[s]);
                slot_mode[s] = MODE_IDLE;
            end
        endfunction

        // one frame tick on one slot
        function void tick_slot(int s);
            logic [47:0] nxt;
            logic [3:0]  chan;
            logic [3:0]  aim;
            bit          done;
            case (slot_mode[s])
                MODE_FADE:
                begin
                    slot_count[s] = slot_count[s] - 8'd1;
                    if (slot_count[s] == 8'd0)
                    begin
                        slot_count[s] = slot_rate[s];
                        nxt  = '0;
                        done = 1'b1;
                        for (int e = 0; e < 4; e++)
                        begin
                            for (int c = 0; c < 3; c++)
                            begin
                                chan = slot_current[s][12*e + 4*c +: 4];
                                aim  = slot_goal[s][12*e + 4*c +: 4];
                                if (chan < aim)
                                    chan = chan + 4'd1;
                                else if (chan > aim)
                                    chan = chan - 4'd1;
                                nxt[12*e + 4*c +: 4] = chan;
                            end
                            if (nxt[12*e +: 12] != slot_goal[s][12*e +: 12])
                                done = 1'b0;
                        end
                        slot_current[s] = nxt;
                        add_write(s, nxt);
                        if (done)
                            slot_mode[s] = MODE_IDLE;
                    end
                end
                MODE_CYCLE:
                begin
                    slot_count[s] = slot_count[s] - 8'd1;
                    if (slot_count[s] == 8'd0)
                    begin
                        slot_count[s] = slot_rate[s];
                        nxt = slot_current[s];
                        // entry 1 takes 2, 2 takes 3, 3 takes the old 1
                        slot_current[s] = {nxt[23:12], nxt[47:36], nxt[35:24], nxt[11:0]};
                        add_write(s, slot_current[s]);
                    end
                end
                MODE_FLASH:
                begin
                    slot_flash_left[s] = slot_flash_left[s] - 8'd1;
                    if (slot_flash_left[s] == 8'd0)
                    begin
                        add_write(s, slot_original[s]);
                        slot_mode[s] = MODE_IDLE;
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        // works out the beats one accepted command causes
        function void accept_command(in_t c);
            int         s;
            logic [11:0] flash_color;
            res_t       r;
            burst.delete();
            case (c.op)
                OP_FADE, OP_CYCLE, OP_FLASH:
                begin
                    s = -1;
                    for (int i = 0; i < SLOTS; i++)
                        if (s < 0 && slot_mode[i] == MODE_IDLE)
                            s = i;
                    if (s < 0 || (c.op == OP_FLASH && c.rate == 8'd0))
                        add_ack(0, 1'b1);
                    else
                    begin
                        slot_plane[s]    = c.plane;
                        slot_pal[s]      = c.palette_index;
                        slot_original[s] = c.palette_now;
                        if (c.op == OP_FLASH)
                        begin
                            flash_color        = c.palette_target[11:0];
                            slot_mode[s]       = MODE_FLASH;
                            slot_flash_left[s] = c.rate;
                            add_write(s, {4{flash_color}});
                        end
                        else
                        begin
                            slot_mode[s]    = (c.op == OP_FADE) ? MODE_FADE : MODE_CYCLE;
                            slot_rate[s]    = (c.rate == 8'd0) ? 8'd1 : c.rate;
                            slot_count[s]   = (c.op == OP_FADE) ? 8'd1 : slot_rate[s];
                            slot_current[s] = c.palette_now;
                            if (c.op == OP_FADE)
                                slot_goal[s] = c.palette_target;
                        end
                        add_ack(s, 1'b0);
                    end
                end
                OP_TICK:
                    for (int i = 0; i < SLOTS; i++)
                        tick_slot(i);
                OP_STOP:
                    if (int'(c.slot_number) < SLOTS)
                        stop_effect(int'(c.slot_number));
                OP_STOPALL:
                    for (int i = 0; i < SLOTS; i++)
                        stop_effect(i);
                OP_QUERY:
                begin
                    r = '0;
                    r.kind     = KIND_STATUS;
                    r.slot_out = c.slot_number;
                    r.active   = (int'(c.slot_number) < SLOTS)
                                 && (slot_mode[c.slot_number] != MODE_IDLE);
                    add_beat(r);
                end
                default:
                begin
                end
            endcase
            if (burst.size() > 0)
                burst[burst.size() - 1].last = 1'b1;
            foreach (burst[i])
                beats_due.push_back(burst[i]);
        endfunction

        function void compare_field(string name, logic [47:0] want, logic [47:0] got);
            if (got !== want)
            begin
                $error("field %s: expected 0x%0h, got 0x%0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_beat(res_t got);
            res_t want;
            if (beats_due.size() == 0)
            begin
                $error("beat with nothing expected: 0x%0h", got);
                mismatches++;
            end
            else
            begin
                want = beats_due.pop_front();
                compare_field("kind", 48'(want.kind), 48'(got.kind));
                compare_field("slot_out", 48'(want.slot_out), 48'(got.slot_out));
                compare_field("failed", 48'(want.failed), 48'(got.failed));
                compare_field("plane_out", 48'(want.plane_out), 48'(got.plane_out));
                compare_field("palette_index_out", 48'(want.palette_index_out),
                              48'(got.palette_index_out));
                compare_field("palette_out", want.palette_out, got.palette_out);
                compare_field("active", 48'(want.active), 48'(got.active));
                compare_field("last", 48'(want.last), 48'(got.last));
            end
        endfunction
    endclass

    effect_slot_scoreboard sb = new();

    palette_effect_slots u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    // 10 ns clock
    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // watchdog, a hung handshake ends the run here
    initial
    begin
        cycles_run = 0;
        while (cycles_run < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles_run++;
        end
        $display("Mismatches found");
        $finish;
    end

    // result side: sample the beat at the edge, then pick the next pop
    // values read here are the ones from before the edge, so the order of
    // processes within the step does not matter
    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
                sb.check_beat(result);
            pop <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    function automatic in_t make_cmd(logic [2:0] op, logic [1:0] plane, logic [3:0] idx,
                                     logic [47:0] now, logic [47:0] target,
                                     logic [7:0] rate, logic [2:0] slot);
        in_t c;
        c.op             = op;
        c.plane          = plane;
        c.palette_index  = idx;
        c.palette_now    = now;
        c.palette_target = target;
        c.rate           = rate;
        c.slot_number    = slot;
        return c;
    endfunction

    function automatic logic [47:0] rand48();
        return 48'({$urandom(), $urandom()});
    endfunction

    // mostly short rates so fades finish and cycles turn, now and then any
    // 8-bit value so every bit is seen and long effects hog slots
    function automatic logic [7:0] pick_rate();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 8'($urandom_range(0, 3));
        else if (roll < 85)
            return 8'($urandom_range(4, 15));
        return 8'($urandom_range(0, 255));
    endfunction

    // random command, weighted toward starts followed by ticks so the slots
    // fill, step, finish and free themselves; the rest is stops, queries
    // and the unused op
    function automatic in_t random_cmd();
        int          roll;
        logic [2:0]  op;
        logic [47:0] now;
        logic [47:0] target;
        roll = $urandom_range(0, 99);
        if (roll < 12)
            op = OP_FADE;
        else if (roll < 21)
            op = OP_CYCLE;
        else if (roll < 30)
            op = OP_FLASH;
        else if (roll < 76)
            op = OP_TICK;
        else if (roll < 84)
            op = OP_STOP;
        else if (roll < 87)
            op = OP_STOPALL;
        else if (roll < 97)
            op = OP_QUERY;
        else
            op = OP_UNUSED;
        now = rand48();
        // half of the fades aim close to the start palette so they end soon
        if ($urandom_range(0, 1))
            target = now ^ (rand48() & 48'h3333_3333_3333);
        else
            target = rand48();
        return make_cmd(op, 2'($urandom_range(0, 2)), 4'($urandom_range(0, 15)), now,
                        target, pick_rate(), 3'($urandom_range(0, 7)));
    endfunction

    // one command beat through push/full, with random gaps in front of it
    // push is written once per step: either lowered for a gap or raised
    task automatic send_command(in_t c);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= c;
        do
            @(posedge clk);
        while (full);
        sb.accept_command(c);
    endtask

    initial
    begin
        push   = 1'b0;
        item   = '0;
        rst_n  = 1'b0;
        steady = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part ---
        // idle block: query, empty tick, unused op, stop of an idle slot
        send_command(make_cmd(OP_QUERY, 2'd0, 4'd0, '0, '0, 8'd0, 3'd0));
        send_command(make_cmd(OP_TICK, 2'd0, 4'd0, '0, '0, 8'd0, 3'd0));
        send_command(make_cmd(OP_UNUSED, 2'd2, 4'd15, '1, '1, 8'hFF, 3'd7));
        send_command(make_cmd(OP_STOP, 2'd0, 4'd0, '0, '0, 8'd0, 3'd3));
        // fade from black to white with a zero rate, taken as one
        send_command(make_cmd(OP_FADE, 2'd0, 4'd0, '0, '1, 8'd0, 3'd0));
        // slowest cycle, it only turns after 255 ticks
        send_command(make_cmd(OP_CYCLE, 2'd2, 4'd15, 48'hFFF_ABC_123_000, '0,
                              8'hFF, 3'd0));
        // flash with no duration is refused
        send_command(make_cmd(OP_FLASH, 2'd1, 4'd7, rand48(), '1, 8'd0, 3'd0));
        // one-tick flash, paints then restores on the next tick
        send_command(make_cmd(OP_FLASH, 2'd1, 4'd7, rand48(), 48'hABC_DEF_123_FFF,
                              8'd1, 3'd0));
        send_command(make_cmd(OP_QUERY, 2'd0, 4'd0, '0, '0, 8'd0, 3'd1));
        send_command(make_cmd(OP_TICK, 2'd0, 4'd0, '0, '0, 8'd0, 3'd0));
        // fast cycle in the freed slot
        send_command(make_cmd(OP_CYCLE, 2'd1, 4'd3, 48'h444_333_222_111, '0,
                              8'd1, 3'd0));
        send_command(make_cmd(OP_TICK, 2'd0, 4'd0, '0, '0, 8'd0, 3'd0));
        // fade already at its goal ends on its first write
        send_command(make_cmd(OP_FADE, 2'd2, 4'd9, 48'h5A5_A5A_0F0_F0F,
                              48'h5A5_A5A_0F0_F0F, 8'd2, 3'd0));
        // fill the bank: white to black fade, cycles and long flashes
        send_command(make_cmd(OP_FADE, 2'd0, 4'd1, '1, '0, 8'd1, 3'd0));
        send_command(make_cmd(OP_CYCLE, 2'd1, 4'd2, rand48(), '0, 8'd2, 3'd0));
        send_command(make_cmd(OP_FLASH, 2'd2, 4'd4, rand48(), rand48(), 8'hFF, 3'd0));
        send_command(make_cmd(OP_FLASH, 2'd0, 4'd8, rand48(), rand48(), 8'h80, 3'd0));
        // no slot left
        send_command(make_cmd(OP_FADE, 2'd0, 4'd0, rand48(), rand48(), 8'd1, 3'd0));
        // every slot busy, a tick writes at most once per slot
        send_command(make_cmd(OP_TICK, 2'd0, 4'd0, '0, '0, 8'd0, 3'd0));
        send_command(make_cmd(OP_TICK, 2'd0, 4'd0, '0, '0, 8'd0, 3'd0));
        send_command(make_cmd(OP_STOP, 2'd0, 4'd0, '0, '0, 8'd0, 3'd1));
        send_command(make_cmd(OP_STOPALL, 2'd0, 4'd0, '0, '0, 8'd0, 3'd0));
        send_command(make_cmd(OP_QUERY, 2'd0, 4'd0, '0, '0, 8'd0, 3'd7));

        // --- random part ---
        for (int n = 0; n < RANDOM_COMMANDS; n++)
        begin
            // a long stretch with no gaps on either side
            steady = (n >= 120 && n < 200);
            // once, hold the sender until every expected beat is out
            if (n == 250)
            begin
                push <= 1'b0;
                @(posedge clk);
                while (sb.beats_due.size() != 0)
                    @(posedge clk);
            end
            send_command(random_cmd());
        end
        push <= 1'b0;

        while (sb.beats_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.beats_due.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/pes_pkg.sv
rtl/pes_front.sv
rtl/pes_back.sv
rtl/pes_out_queue.sv
rtl/palette_effect_slots.sv
rtl/pes_checker.sv
test/testbench.sv
